>>> hdl/serial_eeprom_page_write_memory_top_assert.svh
`ifndef SERIAL_EEPROM_PAGE_WRITE_MEMORY_TOP_ASSERT_SVH
`define SERIAL_EEPROM_PAGE_WRITE_MEMORY_TOP_ASSERT_SVH

// assertion helpers, empty in synthesis
`ifndef SYNTHESIS
`define SEPW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SEPW_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define SEPW_ASSERT(lbl, clk, rstn, prop, msg)
`define SEPW_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

>>> hdl/sepw_pkg.sv
package sepw_pkg;

  localparam int unsigned MEM_DEPTH = 65536;
  localparam int unsigned MAX_PAGE  = 64;

  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned SIZE_W    = 17;
  localparam int unsigned PAGE_W    = 7;
  localparam int unsigned MASK_W    = $clog2(MAX_PAGE);
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CNT_W     = $clog2(ADDR_W);

  localparam logic [SIZE_W-1:0] MIN_SIZE      = SIZE_W'(128);
  localparam logic [SIZE_W-1:0] MAX_SIZE      = SIZE_W'(MEM_DEPTH);
  localparam logic [SIZE_W-1:0] MEM_SIZE_RST  = SIZE_W'(256);
  localparam logic [PAGE_W-1:0] PAGE_SIZE_RST = PAGE_W'(16);
  localparam logic [ADDR_W-1:0] CLR_LAST      = ADDR_W'(MEM_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_LAST      = CNT_W'(ADDR_W - 1);

  localparam logic [KIND_W-1:0] KIND_SEQ_RD  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PAGE_WR = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DIR_RD  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DIR_WR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MEM_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WP        = 2'd2;

  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] dividend;
    logic [SIZE_W-1:0] divisor;
  } sepw_mod_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ADDR_W-1:0] rem;
  } sepw_mod_sts_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    priority if (s < MIN_SIZE) begin
      r = MIN_SIZE;
    end else if (s > MAX_SIZE) begin
      r = MAX_SIZE;
    end else begin
      r = s;
    end
    return r;
  endfunction

  function automatic logic [MASK_W-1:0] page_mask(input logic [PAGE_W-1:0] p);
    logic [MASK_W-1:0] m;
    unique case (p)
      7'd8:    m = MASK_W'(7);
      7'd16:   m = MASK_W'(15);
      7'd32:   m = MASK_W'(31);
      7'd64:   m = MASK_W'(63);
      default: m = MASK_W'(15);
    endcase
    return m;
  endfunction

endpackage

>>> hdl/sepw_ram.sv
module sepw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/sepw_mod.sv
module sepw_mod (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sepw_pkg::sepw_mod_req_t req_i,
  output sepw_pkg::sepw_mod_sts_t sts_o
);
  import sepw_pkg::*;

  logic              busy_q, busy_d;
  logic              fin_q, fin_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ADDR_W-1:0] rem_q, rem_d;
  logic [ADDR_W-1:0] dvd_q, dvd_d;
  logic [SIZE_W-1:0] div_q, div_d;
  logic [SIZE_W-1:0] shifted;
  logic              fast;

  // already below the divisor: no iteration needed
  assign fast    = {1'b0, req_i.dividend} < req_i.divisor;
  assign shifted = {rem_q, dvd_q[ADDR_W-1]};

  always_comb begin
    busy_d = busy_q;
    fin_d  = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    if (busy_q) begin
      if (shifted >= div_q) begin
        rem_d = ADDR_W'(shifted - div_q);
      end else begin
        rem_d = shifted[ADDR_W-1:0];
      end
      dvd_d = {dvd_q[ADDR_W-2:0], 1'b0};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end else if (req_i.start && !fin_q && !fast) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      div_d  = req_i.divisor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = fin_q | (req_i.start & ~busy_q & ~fin_q & fast);
  assign sts_o.rem  = fin_q ? rem_q : req_i.dividend;

endmodule

>>> hdl/serial_eeprom_page_write_memory_top.sv
// channel  | handshake               | payload
// in       | in_valid_i / in_stall_o   | kind_i first_i address_i wdata_i
// out      | out_valid_o / out_stall_i | rdata_o ok_o pointer_o
// cfg      | cfg_valid_i / cfg_ready_o | cfg_index_i cfg_data_i
//
// one request at a time; each reduction by memory size is combinational when the
// address is already below it, else it runs a load, 16 remainder steps and a hand-over
// seq read: 3 reductions (2 without first byte); page write: up to 2 reductions;
// direct read: 1 reduction; direct write: up to 1; clear all zeroes the whole store
// after reset a clearing pass zeroes the whole store before the first request
// a result waiting on out_stall_i holds the next request only at its end

`include "serial_eeprom_page_write_memory_top_assert.svh"

module serial_eeprom_page_write_memory_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [sepw_pkg::KIND_W-1:0]        kind_i,
  input  logic                               first_i,
  input  logic [sepw_pkg::ADDR_W-1:0]        address_i,
  input  logic [sepw_pkg::DATA_W-1:0]        wdata_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [sepw_pkg::DATA_W-1:0]        rdata_o,
  output logic                               ok_o,
  output logic [sepw_pkg::ADDR_W-1:0]        pointer_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sepw_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sepw_pkg::SIZE_W-1:0]        cfg_data_i
);
  import sepw_pkg::*;

  localparam logic [3:0] ST_INIT     = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_DISPATCH = 4'd2;
  localparam logic [3:0] ST_LATCH    = 4'd3;
  localparam logic [3:0] ST_ACCESS   = 4'd4;
  localparam logic [3:0] ST_READ     = 4'd5;
  localparam logic [3:0] ST_PTR      = 4'd6;
  localparam logic [3:0] ST_CLEAR    = 4'd7;
  localparam logic [3:0] ST_RESP     = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [SIZE_W-1:0] mem_size_q;
  logic [PAGE_W-1:0] page_size_q;
  logic              wp_q;

  logic [KIND_W-1:0] kind_q;
  logic              first_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] wdata_q;

  logic [ADDR_W-1:0] bstart_q, bstart_d;
  logic [ADDR_W-1:0] bidx_q, bidx_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [DATA_W-1:0] rdata_q, rdata_d;
  logic              ok_q, ok_d;

  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_rdata_q;
  logic              out_ok_q;
  logic [ADDR_W-1:0] out_ptr_q;
  logic              out_load;

  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] pmask;
  logic [ADDR_W-1:0] target;
  logic [ADDR_W-1:0] access_op;
  logic              in_acc;

  sepw_mod_req_t     mod_req;
  sepw_mod_sts_t     mod_sts;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [DATA_W-1:0] ram_rdata;

  logic              st_idle;
  logic              st_access;
  logic              st_clear;
  logic              st_wr_ok;
  logic              burst_zero;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_size_q  <= MEM_SIZE_RST;
      page_size_q <= PAGE_SIZE_RST;
      wp_q        <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MEM_SIZE:  mem_size_q  <= cfg_data_i;
        CFG_PAGE_SIZE: page_size_q <= cfg_data_i[PAGE_W-1:0];
        CFG_WP:        wp_q        <= cfg_data_i[0];
        default:       ;
      endcase
    end
  end

  // burst position, and its page-wrapped form for page writes
  assign pos    = bstart_q + bidx_q;
  assign pmask  = ADDR_W'(page_mask(page_size_q));
  assign target = (bstart_q & ~pmask) | (pos & pmask);

  always_comb begin
    unique case (kind_q)
      KIND_SEQ_RD:  access_op = pos;
      KIND_PAGE_WR: access_op = target;
      default:      access_op = addr_q;
    endcase
  end

  always_comb begin
    mod_req.start    = 1'b0;
    mod_req.dividend = access_op;
    mod_req.divisor  = eff_size(mem_size_q);
    unique case (state_q)
      ST_LATCH: begin
        mod_req.start    = 1'b1;
        mod_req.dividend = {{(ADDR_W-8){1'b0}}, addr_q[7:0]};
      end
      ST_ACCESS: begin
        mod_req.start = !(kind_q == KIND_PAGE_WR && wp_q);
      end
      ST_PTR: begin
        mod_req.start    = 1'b1;
        mod_req.dividend = pos;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d          = state_q;
    bstart_d         = bstart_q;
    bidx_d           = bidx_q;
    ptr_d            = ptr_q;
    clr_d            = clr_q;
    rdata_d          = rdata_q;
    ok_d             = ok_q;
    out_load         = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = mod_sts.rem;
    ram_wdata        = wdata_q;
    ram_re           = 1'b0;

    unique case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + ADDR_W'(1);
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        rdata_d = '0;
        ok_d    = 1'b1;
        unique case (kind_q)
          KIND_SEQ_RD, KIND_PAGE_WR: begin
            state_d = first_q ? ST_LATCH : ST_ACCESS;
          end
          KIND_DIR_RD: state_d = ST_ACCESS;
          KIND_DIR_WR: begin
            if (wp_q) begin
              ok_d    = 1'b0;
              state_d = ST_RESP;
            end else begin
              state_d = ST_ACCESS;
            end
          end
          KIND_CLEAR: begin
            ptr_d    = '0;
            bstart_d = '0;
            bidx_d   = '0;
            clr_d    = '0;
            state_d  = ST_CLEAR;
          end
          default: state_d = ST_RESP;
        endcase
      end
      ST_LATCH: begin
        if (mod_sts.done) begin
          bstart_d = mod_sts.rem;
          bidx_d   = '0;
          state_d  = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        if (kind_q == KIND_PAGE_WR && wp_q) begin
          bidx_d  = bidx_q + ADDR_W'(1);
          ok_d    = 1'b0;
          state_d = ST_RESP;
        end else begin
          if (mod_sts.done) begin
            unique case (kind_q)
              KIND_SEQ_RD: begin
                ram_re  = 1'b1;
                bidx_d  = bidx_q + ADDR_W'(1);
                state_d = ST_READ;
              end
              KIND_PAGE_WR: begin
                ram_we  = 1'b1;
                bidx_d  = bidx_q + ADDR_W'(1);
                ptr_d   = bstart_q;
                state_d = ST_RESP;
              end
              KIND_DIR_RD: begin
                ram_re  = 1'b1;
                state_d = ST_READ;
              end
              default: begin
                ram_we  = 1'b1;
                state_d = ST_RESP;
              end
            endcase
          end
        end
      end
      ST_READ: begin
        rdata_d = ram_rdata;
        state_d = (kind_q == KIND_SEQ_RD) ? ST_PTR : ST_RESP;
      end
      ST_PTR: begin
        if (mod_sts.done) begin
          ptr_d   = mod_sts.rem;
          state_d = ST_RESP;
        end
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + ADDR_W'(1);
        if (clr_q == CLR_LAST) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      bstart_q    <= '0;
      bidx_q      <= '0;
      ptr_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bstart_q    <= bstart_d;
      bidx_q      <= bidx_d;
      ptr_q       <= ptr_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= rdata_d;
    ok_q    <= ok_d;
    if (in_acc) begin
      kind_q  <= kind_i;
      first_q <= first_i;
      addr_q  <= address_i;
      wdata_q <= wdata_i;
    end
    if (out_load) begin
      out_rdata_q <= rdata_q;
      out_ok_q    <= ok_q;
      out_ptr_q   <= ptr_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rdata_o     = out_rdata_q;
  assign ok_o        = out_ok_q;
  assign pointer_o   = out_ptr_q;

  sepw_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .sts_o  (mod_sts)
  );

  sepw_ram #(
    .Width (DATA_W),
    .Depth (MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (mod_sts.rem),
    .rdata_o (ram_rdata)
  );

  assign st_idle    = (state_q == ST_IDLE);
  assign st_access  = (state_q == ST_ACCESS);
  assign st_clear   = (state_q == ST_CLEAR);
  assign st_wr_ok   = st_access || st_clear || (state_q == ST_INIT);
  assign burst_zero = ~|{ptr_q, bidx_q, bstart_q};

  `SEPW_ASSERT_NEVER(a_mod_idle, clk_i, rst_ni, mod_sts.busy && st_idle, "remainder busy in idle")
  `SEPW_ASSERT(a_we_state, clk_i, rst_ni, ram_we |-> st_wr_ok, "store written out of turn")
  `SEPW_ASSERT(a_we_wp, clk_i, rst_ni, (ram_we && st_access) |-> !wp_q, "write under protect")
  `SEPW_ASSERT(a_clr_ptr, clk_i, rst_ni, st_clear |-> burst_zero, "burst state not cleared")

endmodule
